>>> src/attribute_sort_engine_assert.svh
// assertion macros for the attribute sort engine checker
`ifndef ATTRIBUTE_SORT_ENGINE_ASSERT_SVH
`define ATTRIBUTE_SORT_ENGINE_ASSERT_SVH

// same-cycle implication under reset
`define ASE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("attribute_sort_engine check failed");

// next-cycle implication under reset
`define ASE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("attribute_sort_engine check failed");

`endif

>>> src/ase_pkg.sv
// types, codes and key function shared by the attribute sort engine
`default_nettype none
package ase_pkg;

  localparam int KEY_W = 33;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SORT  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  // criterion codes
  localparam logic [3:0] CRIT_DISTANCE = 4'd0;
  localparam logic [3:0] CRIT_DURATION = 4'd1;
  localparam logic [3:0] CRIT_PACE     = 4'd2;
  localparam logic [3:0] CRIT_CLIMB    = 4'd3;
  localparam logic [3:0] CRIT_DESCENT  = 4'd4;
  localparam logic [3:0] CRIT_HIGH     = 4'd5;
  localparam logic [3:0] CRIT_TYPE     = 4'd6;
  localparam logic [3:0] CRIT_DATE     = 4'd7;
  localparam logic [3:0] CRIT_ID       = 4'd8;
  localparam logic [3:0] CRIT_NONE     = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_KEY,
    ST_SCAN,
    ST_WRITE,
    ST_EM_ORD,
    ST_EM_REC,
    ST_EM_OUT,
    ST_EM_WAIT
  } state_e;

  typedef struct packed {
    logic [15:0]        trk_id;
    logic [23:0]        distance_m;
    logic [19:0]        duration_s;
    logic [15:0]        pace_s_per_km;
    logic [15:0]        climb_m;
    logic [15:0]        descent_m;
    logic signed [14:0] high_point_m;
    logic [3:0]         activity_type;
    logic [31:0]        start_time;
  } rec_t;

  // sort key of one record, larger ranks first
  function automatic logic signed [KEY_W-1:0] key_of(input rec_t r, input logic [3:0] crit);
    logic signed [KEY_W-1:0] k;
    case (crit)
      CRIT_DISTANCE: k = $signed({9'd0, r.distance_m});
      CRIT_DURATION: k = $signed({13'd0, r.duration_s});
      CRIT_PACE:     k = -$signed({17'd0, r.pace_s_per_km});
      CRIT_CLIMB:    k = $signed({17'd0, r.climb_m});
      CRIT_DESCENT:  k = $signed({17'd0, r.descent_m});
      CRIT_HIGH:     k = $signed({{18{r.high_point_m[14]}}, r.high_point_m});
      CRIT_TYPE:     k = $signed({29'd0, r.activity_type});
      CRIT_DATE:     k = $signed({1'b0, r.start_time});
      default:       k = $signed({17'd0, r.trk_id});
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> src/ase_in_if.sv
// request channel of the attribute sort engine
`default_nettype none
interface ase_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [15:0]        trk_id;
  logic [23:0]        distance_m;
  logic [19:0]        duration_s;
  logic [15:0]        pace_s_per_km;
  logic [15:0]        climb_m;
  logic [15:0]        descent_m;
  logic signed [14:0] high_point_m;
  logic [3:0]         activity_type;
  logic [31:0]        start_time;
  logic [3:0]         sort_criteria;

  modport source (output valid, req_type, trk_id, distance_m, duration_s, pace_s_per_km,
                  climb_m, descent_m, high_point_m, activity_type, start_time, sort_criteria,
                  input ready);
  modport sink (input valid, req_type, trk_id, distance_m, duration_s, pace_s_per_km,
                climb_m, descent_m, high_point_m, activity_type, start_time, sort_criteria,
                output ready);
endinterface
`default_nettype wire

>>> src/ase_out_if.sv
// result channel of the attribute sort engine
`default_nettype none
interface ase_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ordered_id;
  logic        last;

  modport source (output valid, ordered_id, last, input ready);
  modport sink (input valid, ordered_id, last, output ready);
endinterface
`default_nettype wire

>>> src/ase_rec_mem.sv
// track record memory, one write and one registered read port
`default_nettype none
module ase_rec_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire ase_pkg::rec_t wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output ase_pkg::rec_t      rdata_o
);
  import ase_pkg::*;

  rec_t mem [DEPTH];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> src/ase_ord_mem.sv
// sorted order memory holding record indices
`default_nettype none
module ase_ord_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [AW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [AW-1:0]      rdata_o
);
  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> src/attribute_sort_engine.sv
// Attribute sort engine. A sort of n stored tracks ranks each track by one pass over
// the record memory: per track a fetch, a key step, a scan of all n records and one
// order write, paced by the single read port of the record memory. A request that
// repeats the last criterion skips the ranking and reverses the direction in which
// the stored order is read. Each id then passes through an order read, a record read,
// the output register and the transfer, which waits out any output stall. No request
// is taken while a sort or its ids are in progress.
`default_nettype none
module attribute_sort_engine #(
  parameter int MAX_TRACKS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ase_in_if.sink    in_i,
  ase_out_if.source out_o
);
  import ase_pkg::*;

  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [3:0]              last_q, last_d;
  logic                    rev_q, rev_d;
  logic [AW-1:0]           i_q, i_d;
  logic [AW-1:0]           scan_q, scan_d;
  logic [AW-1:0]           rank_q, rank_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [15:0]             id_q, id_d;
  logic                    out_valid_q, out_valid_d;
  logic [15:0]             out_id_q;
  logic                    out_last_q;
  logic                    out_load;

  logic                    rec_we;
  rec_t                    rec_wdata, rec_rdata;
  logic [AW-1:0]           rec_raddr;
  logic                    ord_we;
  logic [AW-1:0]           ord_raddr, ord_rdata;

  logic [AW-1:0]           last_idx;
  logic [3:0]              crit_sat;
  logic signed [KEY_W-1:0] key_j;
  logic                    hit;
  req_e                    req;

  assign last_idx = AW'(count_q - CW'(1));
  assign crit_sat = (in_i.sort_criteria > CRIT_ID) ? CRIT_ID : in_i.sort_criteria;
  assign req      = req_e'(in_i.req_type);

  // record built from the load transaction
  assign rec_wdata = '{trk_id: in_i.trk_id, distance_m: in_i.distance_m,
                       duration_s: in_i.duration_s, pace_s_per_km: in_i.pace_s_per_km,
                       climb_m: in_i.climb_m, descent_m: in_i.descent_m,
                       high_point_m: in_i.high_point_m, activity_type: in_i.activity_type,
                       start_time: in_i.start_time};

  // scanned record ranks ahead of the held one
  assign key_j = key_of(rec_rdata, last_q);
  assign hit   = (key_j > key_q) ||
                 ((key_j == key_q) && ((rec_rdata.trk_id < id_q) ||
                                       ((rec_rdata.trk_id == id_q) && (scan_q < i_q))));

  ase_rec_mem #(.DEPTH(MAX_TRACKS), .AW(AW)) u_rec_mem (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  ase_ord_mem #(.DEPTH(MAX_TRACKS), .AW(AW)) u_ord_mem (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (rank_q),
    .wdata_i (i_q),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      last_q      <= CRIT_NONE;
      rev_q       <= 1'b0;
      i_q         <= '0;
      scan_q      <= '0;
      rank_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_q      <= last_d;
      rev_q       <= rev_d;
      i_q         <= i_d;
      scan_q      <= scan_d;
      rank_q      <= rank_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // held key and result payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
    if (out_load) begin
      out_id_q   <= rec_rdata.trk_id;
      out_last_q <= (pos_q == last_idx);
    end
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_d      = last_q;
    rev_d       = rev_q;
    i_d         = i_q;
    scan_d      = scan_q;
    rank_d      = rank_q;
    pos_d       = pos_q;
    key_d       = key_q;
    id_d        = id_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    rec_we      = 1'b0;
    ord_we      = 1'b0;
    rec_raddr   = i_q;
    ord_raddr   = rev_q ? (last_idx - pos_q) : pos_q;
    in_i.ready  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          case (req)
            REQ_LOAD: begin
              if (count_q < CW'(MAX_TRACKS)) begin
                rec_we  = 1'b1;
                count_d = count_q + CW'(1);
                last_d  = CRIT_NONE;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
              last_d  = CRIT_NONE;
            end
            REQ_SORT: begin
              pos_d = '0;
              i_d   = '0;
              if (crit_sat == last_q) begin
                rev_d = ~rev_q;
                if (count_q != '0) state_d = ST_EM_ORD;
              end else begin
                rev_d  = 1'b0;
                last_d = crit_sat;
                if (count_q != '0) state_d = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        rec_raddr = i_q;
        state_d   = ST_KEY;
      end
      ST_KEY: begin
        key_d     = key_of(rec_rdata, last_q);
        id_d      = rec_rdata.trk_id;
        rec_raddr = '0;
        scan_d    = '0;
        rank_d    = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        rec_raddr = scan_q + AW'(1);
        rank_d    = rank_q + AW'(hit);
        scan_d    = scan_q + AW'(1);
        if (scan_q == last_idx) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        ord_we = 1'b1;
        if (i_q == last_idx) begin
          state_d = ST_EM_ORD;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = ST_FETCH;
        end
      end
      ST_EM_ORD: begin
        state_d = ST_EM_REC;
      end
      ST_EM_REC: begin
        rec_raddr = ord_rdata;
        state_d   = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            pos_d   = pos_q + AW'(1);
            state_d = ST_EM_ORD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ordered_id = out_id_q;
  assign out_o.last       = out_last_q;
endmodule
`default_nettype wire

>>> src/ase_checker.sv
// port-level checks of the attribute sort engine and their binding
`default_nettype none
`include "attribute_sort_engine_assert.svh"
module ase_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_id_i,
  input wire logic        out_last_i
);
  logic in_take;
  logic out_take;

  assign in_take  = in_valid_i && in_ready_i;
  assign out_take = out_valid_i && out_ready_i;

  // stalled result holds
  `ASE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_id_i) && $stable(out_last_i))
  // no request taken while an id waits
  `ASE_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_i, !in_ready_i && !in_take)
  // each id is followed by a gap
  `ASE_ASSERT_NXT(a_out_gap, clk_i, rst_ni, out_take, !out_valid_i)
endmodule

bind attribute_sort_engine ase_checker u_ase_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_id_i    (out_o.ordered_id),
  .out_last_i  (out_o.last)
);
`default_nettype wire
